>>> sv/sfv_pkg.sv
package sfv_pkg;

    localparam int unsigned CharWidth   = 8;
    localparam int unsigned LenWidth    = 4;
    localparam int unsigned ReasonWidth = 3;
    localparam int unsigned OutWidth    = 8;

    localparam logic [LenWidth-1:0] BaseMax = LenWidth'(8);
    localparam logic [LenWidth-1:0] ExtMax  = LenWidth'(3);

    localparam logic [CharWidth-1:0] ChNul = 8'h00;
    localparam logic [CharWidth-1:0] ChDot = 8'h2E;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_DOT1  = 3'd1,
        PH_DOT2  = 3'd2,
        PH_BASE  = 3'd3,
        PH_EXT   = 3'd4,
        PH_FAIL  = 3'd5
    } t_phase;

    typedef enum logic [ReasonWidth-1:0] {
        RSN_OK        = 3'd0,
        RSN_BAD_FIRST = 3'd1,
        RSN_FORBIDDEN = 3'd2,
        RSN_BASE_LONG = 3'd3,
        RSN_EXT_LONG  = 3'd4,
        RSN_SECOND_DOT = 3'd5,
        RSN_BAD_DOT   = 3'd6
    } t_reason;

    typedef struct packed {
        logic is_nul;
        logic is_dot;
        logic is_alnum;
        logic is_forbidden;
    } t_char_class;

    typedef struct packed {
        logic    name_ok;
        t_reason reason;
    } t_verdict;

    function automatic logic f_is_forbidden(input logic [CharWidth-1:0] c);
        logic r;
        unique case (c)
            8'h2A, 8'h3F, 8'h3C, 8'h3E, 8'h7C, 8'h22, 8'h2B,
            8'h3D, 8'h2C, 8'h3B, 8'h5B, 8'h5D, 8'h20, 8'hE5: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

>>> sv/short_filename_validator.sv
// Checks a file name against the FAT 8.3 short name rules.
// The slave channel takes the name one character per item, ended by a zero
// character. Every character is checked, but only the zero character
// produces an item on the master channel, carrying the verdict and the
// first reason for rejection; the name state then clears for the next name.
// An accepted character lands in an input register; from there the check
// logic updates the name state and, for a terminator, loads the result
// register, which then shows the result on the master channel, unless the
// terminator waits behind an earlier result.
// Throughput is one character per cycle while no terminator stalls, set by
// the update of the phase and length registers. A waiting result does not
// block further characters; only a second terminator stalls while the
// result register is still full and the receiver holds tready low.
// Reset is synchronous and active low; it clears the input register, the
// result register and the name state, so the block starts at a new name.
module short_filename_validator import sfv_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [CharWidth-1:0] i_s_tdata,   // [7:0] ch
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [OutWidth-1:0]  o_m_tdata    // [0] name_ok, [3:1] reject_reason, [7:4] zero
);

    logic                 r_in_valid;
    logic [CharWidth-1:0] r_in_ch;
    logic                 r_out_valid;
    t_verdict             r_out;
    t_char_class          ch_class;
    t_verdict             verdict;
    logic                 advance;

    assign advance    = r_in_valid && (!ch_class.is_nul || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_ch <= i_s_tdata;
        end
    end

    sfv_char_class u_class (
        .i_ch    (r_in_ch),
        .o_class (ch_class)
    );

    sfv_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (advance),
        .i_class   (ch_class),
        .o_verdict (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && ch_class.is_nul) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && ch_class.is_nul) begin
            r_out <= verdict;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OutWidth - 1 - ReasonWidth){1'b0}}, r_out.reason, r_out.name_ok};

    a_ok_matches_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.name_ok == (r_out.reason == RSN_OK)))
        else $error("name_ok disagrees with reject_reason");

    a_reason_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.reason != 3'd7))
        else $error("reject_reason out of range");

    a_term_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && ch_class.is_nul && r_out_valid && !i_m_tready) |-> !o_s_tready)
        else $error("terminator advanced over a waiting result");

    a_result_from_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid) && $past(i_rst_n)) |->
            $past(r_in_valid && ch_class.is_nul))
        else $error("result appeared without a terminator");

endmodule

>>> sv/sfv_char_class.sv
module sfv_char_class import sfv_pkg::*; (
    input  logic [CharWidth-1:0] i_ch,
    output t_char_class          o_class
);

    always_comb begin
        o_class.is_nul       = (i_ch == ChNul);
        o_class.is_dot       = (i_ch == ChDot);
        o_class.is_alnum     = ((i_ch >= 8'h30) && (i_ch <= 8'h39)) ||
                               ((i_ch >= 8'h41) && (i_ch <= 8'h5A)) ||
                               ((i_ch >= 8'h61) && (i_ch <= 8'h7A));
        o_class.is_forbidden = f_is_forbidden(i_ch);
    end

endmodule

>>> sv/sfv_step.sv
module sfv_step import sfv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_char_class i_class,
    output t_verdict    o_verdict
);

    t_phase                r_phase, n_phase;
    logic [LenWidth-1:0]   r_len, n_len;
    t_reason               r_reason, n_reason;
    t_reason               final_reason;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_len    <= '0;
            r_reason <= RSN_OK;
        end else if (i_en) begin
            r_phase  <= n_phase;
            r_len    <= n_len;
            r_reason <= n_reason;
        end
    end

    always_comb begin
        final_reason = r_reason;
        if (r_phase == PH_START) begin
            final_reason = RSN_BAD_FIRST;
        end else if (r_phase == PH_FAIL && r_reason == RSN_OK) begin
            final_reason = RSN_FORBIDDEN;
        end
        o_verdict.name_ok = (final_reason == RSN_OK);
        o_verdict.reason  = final_reason;
    end

    always_comb begin
        n_phase  = r_phase;
        n_len    = r_len;
        n_reason = r_reason;
        if (i_class.is_nul) begin
            n_phase  = PH_START;
            n_len    = '0;
            n_reason = RSN_OK;
        end else begin
            unique case (r_phase)
                PH_START: begin
                    if (i_class.is_dot) begin
                        n_phase = PH_DOT1;
                    end else if (!i_class.is_alnum) begin
                        n_phase  = PH_FAIL;
                        n_reason = RSN_BAD_FIRST;
                    end else begin
                        n_phase = PH_BASE;
                        n_len   = LenWidth'(1);
                    end
                end
                PH_DOT1: begin
                    if (i_class.is_dot) begin
                        n_phase = PH_DOT2;
                    end else begin
                        n_phase  = PH_FAIL;
                        n_reason = RSN_BAD_DOT;
                    end
                end
                PH_DOT2: begin
                    n_phase  = PH_FAIL;
                    n_reason = RSN_BAD_DOT;
                end
                PH_BASE: begin
                    if (i_class.is_forbidden) begin
                        n_phase  = PH_FAIL;
                        n_reason = RSN_FORBIDDEN;
                    end else if (i_class.is_dot) begin
                        n_phase = PH_EXT;
                        n_len   = '0;
                    end else if (r_len >= BaseMax) begin
                        n_phase  = PH_FAIL;
                        n_reason = RSN_BASE_LONG;
                    end else begin
                        n_len = r_len + LenWidth'(1);
                    end
                end
                PH_EXT: begin
                    if (i_class.is_forbidden) begin
                        n_phase  = PH_FAIL;
                        n_reason = RSN_FORBIDDEN;
                    end else if (i_class.is_dot) begin
                        n_phase  = PH_FAIL;
                        n_reason = RSN_SECOND_DOT;
                    end else if (r_len >= ExtMax) begin
                        n_phase  = PH_FAIL;
                        n_reason = RSN_EXT_LONG;
                    end else begin
                        n_len = r_len + LenWidth'(1);
                    end
                end
                default: begin
                    n_phase = PH_FAIL;
                end
            endcase
        end
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import sfv_pkg::*;

    localparam int unsigned IdleLimit   = 4000;
    localparam int unsigned HoldCycles  = 300;
    localparam int unsigned MaxReported = 10;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [CharWidth-1:0] i_s_tdata = '0;   // [7:0] ch
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [OutWidth-1:0]  o_m_tdata;        // [0] name_ok, [3:1] reject_reason, [7:4] zero

    short_filename_validator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    t_phase              name_phase  = PH_START;
    logic [LenWidth-1:0] part_len    = '0;
    t_reason             first_fault = RSN_OK;
    t_verdict            pending_verdicts[$];
    t_verdict            got_verdict;

    int unsigned idle_pct     = 0;
    int unsigned stall_pct    = 0;
    int unsigned hold_req     = 0;
    int unsigned hold_cnt     = 0;
    int unsigned chars_sent   = 0;
    int unsigned fail_count   = 0;
    int unsigned quiet_cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic is_banned_char(input logic [CharWidth-1:0] c);
        case (c)
            "*", "?", "<", ">", "|", "\"", "+", "=", ",", ";", "[", "]", " ", 8'hE5:
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic logic is_alnum_char(input logic [CharWidth-1:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic void latch_fault(input t_reason r);
        name_phase  = PH_FAIL;
        first_fault = r;
    endfunction

    // Mirrors the name state for one accepted character and queues a verdict
    // when the character is the terminator.
    function automatic void advance_name_check(input logic [CharWidth-1:0] c);
        t_reason  rsn;
        t_verdict v;
        if (c == ChNul) begin
            rsn = first_fault;
            if (name_phase == PH_START) begin
                rsn = RSN_BAD_FIRST;
            end else if (name_phase == PH_FAIL && rsn == RSN_OK) begin
                rsn = RSN_FORBIDDEN;
            end
            v.name_ok = (rsn == RSN_OK);
            v.reason  = rsn;
            pending_verdicts.push_back(v);
            name_phase  = PH_START;
            part_len    = '0;
            first_fault = RSN_OK;
            return;
        end
        case (name_phase)
            PH_START: begin
                if (c == ChDot) begin
                    name_phase = PH_DOT1;
                end else if (!is_alnum_char(c)) begin
                    latch_fault(RSN_BAD_FIRST);
                end else begin
                    name_phase = PH_BASE;
                    part_len   = LenWidth'(1);
                end
            end
            PH_DOT1: begin
                if (c == ChDot) begin
                    name_phase = PH_DOT2;
                end else begin
                    latch_fault(RSN_BAD_DOT);
                end
            end
            PH_DOT2: latch_fault(RSN_BAD_DOT);
            PH_BASE: begin
                if (is_banned_char(c)) begin
                    latch_fault(RSN_FORBIDDEN);
                end else if (c == ChDot) begin
                    name_phase = PH_EXT;
                    part_len   = '0;
                end else if (part_len >= BaseMax) begin
                    latch_fault(RSN_BASE_LONG);
                end else begin
                    part_len = part_len + 1'b1;
                end
            end
            PH_EXT: begin
                if (is_banned_char(c)) begin
                    latch_fault(RSN_FORBIDDEN);
                end else if (c == ChDot) begin
                    latch_fault(RSN_SECOND_DOT);
                end else if (part_len >= ExtMax) begin
                    latch_fault(RSN_EXT_LONG);
                end else begin
                    part_len = part_len + 1'b1;
                end
            end
            default: name_phase = PH_FAIL;
        endcase
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= MaxReported) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endfunction

    function automatic logic [CharWidth-1:0] pick_alnum();
        int k;
        k = $urandom_range(0, 61);
        if (k < 10) begin
            return CharWidth'("0" + k);
        end else if (k < 36) begin
            return CharWidth'("A" + k - 10);
        end
        return CharWidth'("a" + k - 36);
    endfunction

    function automatic logic [CharWidth-1:0] pick_name_char();
        logic [CharWidth-1:0] c;
        if ($urandom_range(0, 1) == 0) begin
            return pick_alnum();
        end
        do begin
            c = CharWidth'($urandom_range(1, 255));
        end while (is_banned_char(c) || c == ChDot);
        return c;
    endfunction

    // Called right after a rising edge; returns right after the edge that
    // accepted the item, leaving tvalid high for the next call to decide.
    task automatic send_char(input logic [CharWidth-1:0] c);
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        advance_name_check(c);
        chars_sent++;
    endtask

    task automatic send_name(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i]);
        end
        send_char(ChNul);
    endtask

    task automatic send_random_name();
        logic [CharWidth-1:0] name_q[$];
        int kind;
        int base_len;
        int ext_len;
        int pos;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            base_len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
            name_q.push_back(pick_alnum());
            repeat (base_len - 1) name_q.push_back(pick_name_char());
            if ($urandom_range(0, 3) != 0) begin
                name_q.push_back(ChDot);
                ext_len = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 5)
                                                      : $urandom_range(0, 3);
                repeat (ext_len) name_q.push_back(pick_name_char());
            end
            if ($urandom_range(0, 4) == 0) begin
                pos = $urandom_range(0, name_q.size() - 1);
                name_q[pos] = ($urandom_range(0, 2) == 0) ? ChDot
                                                          : CharWidth'($urandom_range(1, 255));
            end
        end else if (kind < 80) begin
            name_q.push_back(ChDot);
            if ($urandom_range(0, 1) == 1) name_q.push_back(ChDot);
            if ($urandom_range(0, 2) == 0) name_q.push_back(CharWidth'($urandom_range(1, 255)));
        end else begin
            repeat ($urandom_range(0, 10)) name_q.push_back(CharWidth'($urandom_range(1, 255)));
        end
        foreach (name_q[i]) begin
            send_char(name_q[i]);
        end
        send_char(ChNul);
    endtask

    task automatic test_directed_names();
        idle_pct  = 0;
        stall_pct = 0;
        send_name("");
        send_name(".");
        send_name("..");
        send_name(".a");
        send_name("A..");
        send_char(8'h80);
        send_char(ChNul);
        send_char("A");
        send_char(8'hFF);
        send_char(ChDot);
        send_char(ChNul);
        send_char("Z");
        send_char(8'hE5);
        send_char(ChNul);
    endtask

    task automatic test_random_names(input int unsigned send_idle, input int unsigned recv_stall,
                                     input int unsigned n_chars);
        int unsigned first;
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        first     = chars_sent;
        while (chars_sent - first < n_chars) begin
            send_random_name();
        end
    endtask

    // The receiver stops for a long stretch while names keep coming, so the
    // result register fills and the block must stall its input.
    task automatic test_output_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        hold_req <= HoldCycles;
        send_name("X");
        send_name("Q.7");
        send_name("..");
        send_name("K9");
        repeat (4) send_random_name();
    endtask

    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_cnt = hold_req;
            hold_req <= 0;
        end
        if (hold_cnt != 0) begin
            hold_cnt--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_verdicts.size() == 0) begin
                note_failure($sformatf("unexpected result tdata=%02h", o_m_tdata));
            end else begin
                got_verdict = pending_verdicts.pop_front();
                if (o_m_tdata[0] !== got_verdict.name_ok ||
                    o_m_tdata[3:1] !== got_verdict.reason ||
                    o_m_tdata[7:4] !== 4'b0) begin
                    note_failure($sformatf(
                        "mismatch: expected ok=%0d reason=%0d pad=0, got ok=%0d reason=%0d pad=%0h",
                        got_verdict.name_ok, got_verdict.reason,
                        o_m_tdata[0], o_m_tdata[3:1], o_m_tdata[7:4]));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= IdleLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_names();
        test_random_names(0, 0, 260);
        test_random_names(86, 0, 260);
        test_random_names(0, 86, 260);
        test_random_names(23, 23, 260);
        test_output_backpressure();
        i_s_tvalid <= 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (pending_verdicts.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", pending_verdicts.size()));
        end
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
